// File: hdl/kos_pkg.sv
// shared types and constants for the kth-one select unit
package kos_pkg;

  localparam int POS_W = 11;
  localparam int OP_W = 2;
  localparam int POSITIONS_DEFAULT = 1024;
  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_LEAF,
    ST_UPD_UP,
    ST_FIND_RD,
    ST_FIND_ROOT,
    ST_FIND_DOWN
  } state_t;

endpackage

// File: hdl/kth_one_select_bitvector_unit.sv
// kth-one select over a bit vector, count tree walked one level per cycle
//
// Requests come in on in_valid/in_ready with opcode, position, bit_value
// and rank. Write (opcode 0) and toggle (opcode 1) change one bit and give
// no result; find (opcode 2) gives one result on out_valid/out_ready with
// found_position and not_found. Opcode 3, and writes or toggles to a
// position of zero or beyond the size in use, are taken and dropped.
// The counts live in one ram holding a perfect binary tree of
// 2*2^L entries, L = clog2(POSITIONS). All tree work is done by that ram
// and one adder/comparator, one tree level per cycle. A write or toggle
// stops after the leaf when the bit does not change; after a find the
// next request is taken only once its result has gone to the output
// register. in_ready is high only while the unit is idle.
// A finished result sits in the output register; a new request is taken
// while it waits, but a find stalls at its end until the slot is free.
// After rst the ram is cleared one entry per cycle, all 2^(L+1) entries
// (2048 at 1024 positions), with in_ready low. size_in_use is written
// through cfg_wr_en/cfg_wr_data at any time and resets to 1024.
module kth_one_select_bitvector_unit #(
  parameter int POSITIONS = kos_pkg::POSITIONS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [kos_pkg::POS_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [kos_pkg::OP_W-1:0] opcode,
  input  logic [kos_pkg::POS_W-1:0] position,
  input  logic                     bit_value,
  input  logic [kos_pkg::POS_W-1:0] rank,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [kos_pkg::POS_W-1:0] found_position,
  output logic                     not_found
);

  import kos_pkg::*;

  localparam int LVL = $clog2(POSITIONS);
  localparam int NODE_W = LVL + 1;
  localparam int DEPTH = 2 ** NODE_W;
  localparam int CW = $clog2(POSITIONS + 1);
  localparam int NEED_W = (CW > POS_W) ? CW : POS_W;
  localparam int WIDE_W = (NODE_W > POS_W) ? NODE_W : POS_W;
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(1) << LVL;
  localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);
  localparam logic [WIDE_W-1:0] POS_LIMIT = WIDE_W'(POSITIONS);

  state_t              state, state_next;
  logic                done;
  logic                done_next;
  logic [NODE_W-1:0]   node, node_next;
  logic [NEED_W-1:0]   need, need_next;
  logic [OP_W-1:0]     op, op_next;
  logic                bit_val, bit_val_next;
  logic                inc, inc_next;
  logic                miss, miss_next;
  logic [POS_W-1:0]    size_in_use;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  logic [CW-1:0]       ram_wdata;
  logic [NODE_W-1:0]   ram_raddr;
  logic [CW-1:0]       rdata;

  logic                in_fire;
  logic [WIDE_W-1:0]   used_w;
  logic                pos_ok;
  logic [POS_W-1:0]    pos_m1;
  logic                old_bit, new_bit;
  logic                go_right;
  logic [NODE_W-1:0]   child;
  logic                last_level;
  logic [WIDE_W-1:0]   leaf_pos;
  logic                hit;
  logic                slot_free;

  kos_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == ST_IDLE) && !done;
  assign in_fire = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign used_w = (WIDE_W'(size_in_use) > POS_LIMIT) ? POS_LIMIT : WIDE_W'(size_in_use);
  assign pos_ok = (position != '0) && (WIDE_W'(position) <= used_w);
  assign pos_m1 = position - POS_W'(1);

  assign old_bit = rdata[0];
  assign new_bit = (op == OP_WRITE) ? bit_val : !old_bit;

  // descend: left count is in rdata, go right when the rank lies past it
  assign go_right = need > NEED_W'(rdata);
  assign child = {node[NODE_W-2:0], go_right};
  assign last_level = node[LVL-1];

  assign leaf_pos = WIDE_W'(node[LVL-1:0]) + WIDE_W'(1);
  assign hit = !miss && (leaf_pos <= used_w);

  // next state
  always_comb begin
    state_next = state;
    done_next = done;
    case (state)
      ST_CLEAR: begin
        if (node == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (done) begin
          if (slot_free) begin
            done_next = 1'b0;
          end
        end else if (in_fire) begin
          if ((opcode == OP_WRITE || opcode == OP_TOGGLE) && pos_ok) begin
            state_next = ST_UPD_RD;
          end else if (opcode == OP_FIND) begin
            if (rank == '0) begin
              done_next = 1'b1;
            end else begin
              state_next = ST_FIND_RD;
            end
          end
        end
      end
      ST_UPD_RD: state_next = ST_UPD_LEAF;
      ST_UPD_LEAF: begin
        state_next = (new_bit != old_bit) ? ST_UPD_UP : ST_IDLE;
      end
      ST_UPD_UP: begin
        if (node == ROOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIND_RD: state_next = ST_FIND_ROOT;
      ST_FIND_ROOT: begin
        if (need > NEED_W'(rdata)) begin
          state_next = ST_IDLE;
          done_next = 1'b1;
        end else begin
          state_next = ST_FIND_DOWN;
        end
      end
      ST_FIND_DOWN: begin
        if (last_level) begin
          state_next = ST_IDLE;
          done_next = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    node_next = node;
    need_next = need;
    op_next = op;
    bit_val_next = bit_val;
    inc_next = inc;
    miss_next = miss;
    ram_we = 1'b0;
    ram_waddr = node;
    ram_wdata = '0;
    ram_raddr = node;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        node_next = node + NODE_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_next = opcode;
          bit_val_next = bit_value;
          need_next = NEED_W'(rank);
          miss_next = (rank == '0);
          if (opcode == OP_FIND) begin
            node_next = ROOT;
          end else begin
            node_next = LEAF_BASE | NODE_W'(pos_m1);
          end
        end
      end
      ST_UPD_RD: ram_raddr = node;
      ST_UPD_LEAF: begin
        ram_we = 1'b1;
        ram_wdata = CW'(new_bit);
        ram_raddr = node >> 1;
        inc_next = new_bit;
        node_next = node >> 1;
      end
      ST_UPD_UP: begin
        ram_we = 1'b1;
        ram_wdata = inc ? rdata + CW'(1) : rdata - CW'(1);
        ram_raddr = node >> 1;
        node_next = node >> 1;
      end
      ST_FIND_RD: ram_raddr = node;
      ST_FIND_ROOT: begin
        ram_raddr = {node[NODE_W-2:0], 1'b0};
        if (need > NEED_W'(rdata)) begin
          miss_next = 1'b1;
        end
      end
      ST_FIND_DOWN: begin
        ram_raddr = {child[NODE_W-2:0], 1'b0};
        node_next = child;
        if (go_right) begin
          need_next = need - NEED_W'(rdata);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done <= 1'b0;
      node <= '0;
      size_in_use <= SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      node <= node_next;
      if (cfg_wr_en) begin
        size_in_use <= cfg_wr_data;
      end
      if (done && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    need <= need_next;
    op <= op_next;
    bit_val <= bit_val_next;
    inc <= inc_next;
    miss <= miss_next;
    if (done && slot_free) begin
      found_position <= hit ? leaf_pos[POS_W-1:0] : '0;
      not_found <= !hit;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_found |-> found_position == '0)
    else $error("not_found result carries a nonzero position");

  a_rank_zero: assert property (@(posedge clk) disable iff (rst)
    in_fire && opcode == OP_FIND && rank == '0 && !out_valid |-> ##2 (out_valid && not_found))
    else $error("find of rank zero did not give a miss");

  a_need_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIND_DOWN |-> need != '0 && !miss)
    else $error("descent running with nothing left to find");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIND_ROOT |-> WIDE_W'(rdata) <= POS_LIMIT)
    else $error("root count above the number of positions");

  a_up_node: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD_UP |-> node != '0 && node < LEAF_BASE)
    else $error("count update left the tree");

endmodule

// File: hdl/kos_ram.sv
// generic single-write, single-read ram with registered read data
module kos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
